FILE: rtl/core/gfr_pkg.sv
package gfr_pkg;

  // Panel defaults
  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;

  // Glyph geometry
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int FONT_GLYPHS = 41;
  localparam int FONT_BYTES  = FONT_GLYPHS * GLYPH_COLS;
  localparam int SLOT_W      = 6;
  localparam int FONT_IDX_W  = $clog2(FONT_BYTES);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input transaction opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Bounds of the digit and letter ranges, and character codes with a glyph outside them
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  // Classified command kinds
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_CLEAR,
    KIND_DRAW,
    KIND_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         x_pos;
    logic [7:0]         y_pos;
    logic [SLOT_W-1:0]  slot;
    logic [2:0]         scale;
    logic [9:0]         read_index;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_COL,
    ST_BYTE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } back_state_t;

  // 5x7 column-major font, bit 0 is the top row; glyph g at g*5
  localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36,
    8'h3E,8'h41,8'h41,8'h41,8'h22, 8'h7F,8'h41,8'h41,8'h22,8'h1C,
    8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
    8'h3E,8'h41,8'h49,8'h49,8'h7A, 8'h7F,8'h08,8'h08,8'h08,8'h7F,
    8'h00,8'h41,8'h7F,8'h41,8'h00, 8'h20,8'h40,8'h41,8'h3F,8'h01,
    8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h0C,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F,
    8'h3E,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h09,8'h09,8'h09,8'h06,
    8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01,
    8'h3F,8'h40,8'h40,8'h40,8'h3F, 8'h1F,8'h20,8'h40,8'h20,8'h1F,
    8'h3F,8'h40,8'h38,8'h40,8'h3F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h07,8'h08,8'h70,8'h08,8'h07, 8'h61,8'h51,8'h49,8'h45,8'h43,
    8'h23,8'h13,8'h08,8'h64,8'h62, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02
  };

  // Glyph slot for a character code; MSB set when the code has a glyph
  function automatic logic [SLOT_W:0] font_slot(input logic [7:0] code);
    logic [SLOT_W:0] res;
    res = '0;
    if (code >= CH_DIGIT_0 && code <= CH_DIGIT_9) begin
      res = {1'b1, SLOT_W'(code - CH_DIGIT_0)};
    end else if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
      res = {1'b1, SLOT_W'(code - CH_UPPER_A) + SLOT_W'(10)};
    end else begin
      case (code)
        CH_PERCENT: res = {1'b1, SLOT_W'(36)};
        CH_MINUS:   res = {1'b1, SLOT_W'(37)};
        CH_COLON:   res = {1'b1, SLOT_W'(38)};
        CH_PERIOD:  res = {1'b1, SLOT_W'(39)};
        CH_SLASH:   res = {1'b1, SLOT_W'(40)};
        default:    res = '0;
      endcase
    end
    return res;
  endfunction

  // One font column of a glyph
  function automatic logic [GLYPH_ROWS-1:0] font_column(input logic [SLOT_W-1:0] slot,
                                                        input logic [2:0] col);
    logic [FONT_IDX_W-1:0] idx;
    idx = FONT_IDX_W'(slot * GLYPH_COLS) + FONT_IDX_W'(col);
    return FONT_ROM[idx][GLYPH_ROWS-1:0];
  endfunction

endpackage

FILE: rtl/core/glyph_framebuffer_renderer_unit.sv
// Monochrome page-organized framebuffer (PANEL_WIDTH x PANEL_HEIGHT, 8 vertical
// pixels per byte, bit 0 on top) with a built-in 5x7 font. Each input transaction
// carries a command: clear, draw character, or read one byte; every command gives
// exactly one output transaction (the byte for a read, zero otherwise). Commands
// pass through a two-entry queue to a sequencer that owns the store, with one read
// and one write port. After reset, and for every clear, the sequencer sweeps the
// store one byte per cycle over all PANEL_WIDTH * ceil(PANEL_HEIGHT/8) bytes (1024
// by default); in_tready stays low during the reset sweep. A draw walks the
// 5*scale screen columns of the glyph; each has a setup step, then visits the eight
// page slots of its pixel window, with a read-modify-write for each touched byte
// (at most two per screen column at scale 1). Draws of unknown characters or at
// scale 0 become no-ops.
module glyph_framebuffer_renderer_unit #(
  parameter int PANEL_WIDTH  = gfr_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = gfr_pkg::DEF_PANEL_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], x_pos[9:2], y_pos[17:10], char_code[25:18],
                                  // scale[28:26], read_index[38:29], zero[39]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // read_data[7:0]
);
  import gfr_pkg::*;

  logic init_busy;
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // Decode and classify
  gfr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .init_busy (init_busy),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // Command queue
  gfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // Store sequencer and output register
  gfr_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/core/gfr_front.sv
module gfr_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,   // op[1:0], x_pos, y_pos, char_code, scale, read_index
  input  logic          init_busy,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output gfr_pkg::cmd_t cmd
);
  import gfr_pkg::*;

  logic [1:0]        op;
  logic [7:0]        char_code;
  logic [SLOT_W:0]   slot_lkp;
  logic              blank;
  cmd_kind_t         kind;

  // Unpack the transaction
  assign op        = in_tdata[1:0];
  assign char_code = in_tdata[25:18];
  assign slot_lkp  = font_slot(char_code);

  assign cmd.x_pos      = in_tdata[9:2];
  assign cmd.y_pos      = in_tdata[17:10];
  assign cmd.scale      = in_tdata[28:26];
  assign cmd.read_index = in_tdata[38:29];
  assign cmd.slot       = slot_lkp[SLOT_W-1:0];
  assign cmd.kind       = kind;

  // A draw of a character without a glyph, or at scale 0, turns into a no-op
  assign blank = !slot_lkp[SLOT_W] || (in_tdata[28:26] == 3'd0);

  // Classify
  always_comb begin
    unique case (op)
      OP_CLEAR: kind = KIND_CLEAR;
      OP_DRAW:  kind = blank ? KIND_NOP : KIND_DRAW;
      OP_READ:  kind = KIND_READ;
      default:  kind = KIND_NOP;
    endcase
  end

  // Hold off input while the store is being cleared after reset
  assign cmd_valid = in_tvalid && !init_busy;
  assign in_tready = cmd_ready && !init_busy;

endmodule

FILE: rtl/core/gfr_queue.sv
module gfr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gfr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gfr_pkg::cmd_t pop_cmd
);
  import gfr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/gfr_back.sv
module gfr_back #(
  parameter int PANEL_WIDTH  = gfr_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = gfr_pkg::DEF_PANEL_HEIGHT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  gfr_pkg::cmd_t cmd,
  output logic          init_busy,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata    // read_data
);
  import gfr_pkg::*;

  localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  // One bit above both the read index and the store size
  localparam int IDXW        = ((AW > 10) ? AW : 10) + 1;

  // Framebuffer memory
  logic [7:0]    mem [STORE_BYTES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rd_q_r;

  back_state_t   state_r, state_nxt;
  cmd_t          cmd_r;
  logic [AW-1:0] ptr_r;
  logic [2:0]    col_r, dx_r, m_r;
  logic [7:0]    x_r;
  logic [63:0]   win_r;
  logic [7:0]    mask_r;
  logic [AW-1:0] addr_r;
  logic          hit_r;
  logic [7:0]    res_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;

  logic [7:0]    x_cur;
  logic          x_on;
  logic [4:0]    page;
  logic          page_on;
  logic [7:0]    bmask;
  logic [AW-1:0] byte_addr;
  logic          col_last, byte_last, dx_last, ptr_last;
  logic [63:0]   win;
  logic [7:0]    rep;
  logic [IDXW-1:0] ridx;
  logic          ridx_hit;
  logic          out_free;
  logic          touch;

  // Column, page and address arithmetic
  assign x_cur     = cmd_r.x_pos + ({5'd0, col_r} * {5'd0, cmd_r.scale}) + 8'(dx_r);
  assign x_on      = {1'b0, x_cur} < 9'(PANEL_WIDTH);
  assign page      = cmd_r.y_pos[7:3] + 5'(m_r);
  assign page_on   = {1'b0, page} < 6'(PAGES);
  assign bmask     = win_r[{m_r, 3'b000} +: 8];
  assign byte_addr = AW'(x_r) + AW'(32'(page) * PANEL_WIDTH);
  assign touch     = (bmask != 8'd0) && page_on;
  assign dx_last   = (dx_r == cmd_r.scale - 3'd1);
  assign col_last  = dx_last && (col_r == 3'(GLYPH_COLS - 1));
  assign byte_last = (m_r == 3'd7);
  assign ptr_last  = (ptr_r == AW'(STORE_BYTES - 1));
  assign ridx      = IDXW'(cmd_r.read_index);
  assign ridx_hit  = ridx < IDXW'(STORE_BYTES);
  assign out_free  = !out_valid_r || out_tready;

  // Vertical pixel run of one glyph column, expanded by scale and aligned to its page
  always_comb begin
    logic [GLYPH_ROWS-1:0] bits;
    bits = font_column(cmd_r.slot, col_r);
    rep  = 8'((9'd1 << cmd_r.scale) - 9'd1);
    win  = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      if (bits[r]) begin
        win = win | (64'(rep) << (6'(6'(r) * 6'(cmd_r.scale)) + 6'(cmd_r.y_pos[2:0])));
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:  if (ptr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            KIND_CLEAR: state_nxt = ST_CLEAR;
            KIND_DRAW:  state_nxt = ST_COL;
            KIND_READ:  state_nxt = ST_READ;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: if (ptr_last) state_nxt = ST_DONE;
      ST_COL: begin
        if (x_on) state_nxt = ST_BYTE;
        else if (col_last) state_nxt = ST_DONE;
      end
      ST_BYTE: begin
        if (touch) state_nxt = ST_WRITE;
        else if (byte_last) state_nxt = col_last ? ST_DONE : ST_COL;
      end
      ST_WRITE: begin
        if (byte_last) state_nxt = col_last ? ST_DONE : ST_COL;
        else state_nxt = ST_BYTE;
      end
      ST_READ:      state_nxt = ST_READ_WAIT;
      ST_READ_WAIT: state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_INIT;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_r;
    mem_raddr = byte_addr;
    mem_wdata = 8'd0;
    cmd_ready = 1'b0;
    unique case (state_r) inside
      ST_INIT, ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  cmd_ready = 1'b1;
      ST_BYTE:  mem_re = touch;
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = rd_q_r | mask_r;
      end
      ST_READ: begin
        mem_re    = ridx_hit;
        mem_raddr = ridx[AW-1:0];
      end
      default: ;
    endcase
  end

  assign init_busy  = (state_r == ST_INIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT || state_r == ST_CLEAR) begin
        ptr_r <= ptr_last ? '0 : ptr_r + 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid) begin
      cmd_r <= cmd;
      col_r <= '0;
      dx_r  <= '0;
      res_r <= 8'd0;
    end
    if (state_r == ST_COL) begin
      x_r   <= x_cur;
      win_r <= win;
      m_r   <= '0;
    end
    // Step to the next screen column of the glyph
    if ((state_r == ST_COL && !x_on) ||
        ((state_r == ST_WRITE || (state_r == ST_BYTE && !touch)) && byte_last)) begin
      if (dx_last) begin
        dx_r  <= '0;
        col_r <= col_r + 3'd1;
      end else begin
        dx_r <= dx_r + 3'd1;
      end
    end
    if ((state_r == ST_BYTE && !touch && !byte_last) ||
        (state_r == ST_WRITE && !byte_last)) begin
      m_r <= m_r + 3'd1;
    end
    if (state_r == ST_BYTE && touch) begin
      addr_r <= byte_addr;
      mask_r <= bmask;
    end
    if (state_r == ST_READ) begin
      hit_r <= ridx_hit;
    end
    if (state_r == ST_READ_WAIT) begin
      res_r <= hit_r ? rd_q_r : 8'd0;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
    end
  end

  // Store access
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_raddr];
    end
  end

endmodule
